### rtl/rffd_pkg.sv
// ----------------------------------------------------------------------------
// rffd_pkg: shared types and tables for the rf remote frame decoder
// beat structs for both channels, frame field constants, house byte table
// ----------------------------------------------------------------------------
package rffd_pkg;

	typedef struct packed {
		logic [31:0] frame_code;
		logic [6:0]  bit_count;
		logic [31:0] now_ms;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]  house_index;
		logic [5:0]  button_number;
		logic        is_on;
		logic [31:0] raw_code;
		logic [31:0] event_time_ms;
	} out_beat_t;

	localparam logic [31:0] DEBOUNCE_RESET_MS = 32'd250;
	localparam logic [6:0]  FRAME_BITS        = 7'd24;
	localparam logic [3:0]  MARKER_NIB        = 4'h1;
	localparam logic [3:0]  ONOFF_OFF         = 4'h4;
	localparam logic [3:0]  ONOFF_ON          = 4'h5;

	localparam logic [7:0] HOUSE_BYTES [16] = '{
		8'h00, 8'h40, 8'h10, 8'h04, 8'h44, 8'h14, 8'h54, 8'h01,
		8'h41, 8'h11, 8'h51, 8'h05, 8'h45, 8'h15, 8'h55, 8'h50
	};

	// house byte match, one compare per table entry
	function automatic logic house_hit(input logic [7:0] b);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (HOUSE_BYTES[i] == b) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic [3:0] house_idx(input logic [7:0] b);
		logic [3:0] idx;
		idx = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (HOUSE_BYTES[i] == b) idx = 4'(i);
		end
		return idx;
	endfunction

	// row/slider nibble legal codes 0,4,1,5
	function automatic logic nib_ok(input logic [3:0] n);
		return (n[3:1] == 3'b000) || (n[3:1] == 3'b010);
	endfunction

	// position minus one: 0->0, 4->1, 1->2, 5->3
	function automatic logic [1:0] nib_idx(input logic [3:0] n);
		return {n[0], n[2]};
	endfunction

endpackage

### rtl/rf_remote_frame_decoder_top.sv
// a decoded frame goes into the queue, then into the output register behind out_valid
// throughput: one input beat per cycle; in_stall holds input only while the queue is full
// a queued result moves into the output register at the edge that takes the previous one
// reset: arst_n clears the queue, output valid, last code and last time; window returns to 250
// ----------------------------------------------------------------------------
// rf_remote_frame_decoder_top: decoder for rf remote frames with debounce
// front classifies beats, a fifo decouples it from the output register
// ----------------------------------------------------------------------------
module rf_remote_frame_decoder_top
	import rffd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel: one received code per beat
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_beat,
	// result channel: one decoded frame per beat
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_beat,
	// debounce window register, write only
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// front to queue
	logic      q_push;
	out_beat_t q_push_data;
	logic      q_full;
	// queue to back
	logic      q_pop;
	logic      q_not_empty;
	out_beat_t q_head;

	// front: debounce against the last code, frame checks, decode
	// zero codes and repeats inside the window are dropped without a state update
	rffd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_push_data)
	);

	// queue: holds decoded frames while the result side stalls
	rffd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: registered result beat
	rffd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_beat    (out_beat)
	);

endmodule

### rtl/rffd_front.sv
// ----------------------------------------------------------------------------
// rffd_front: input acceptance, debounce and frame classification
// keeps the last code and its time, decodes valid frames into the queue
// ----------------------------------------------------------------------------
module rffd_front
	import rffd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_beat,
	input  logic      cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic      q_full,
	output logic      q_push,
	output out_beat_t q_data
);

	logic [31:0] window_q;
	logic [31:0] last_code_q;
	logic [31:0] last_time_q;

	logic        accept;
	logic        is_repeat;
	logic        take;
	logic        frame_ok;
	logic [31:0] elapsed;
	logic [7:0]  house_byte;
	logic [3:0]  row_nib, slider_nib, marker_nib, onoff_nib;
	logic [1:0]  row_idx, slider_idx;
	logic        on_flag;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign elapsed   = in_beat.now_ms - last_time_q;
	assign is_repeat = (in_beat.frame_code == last_code_q) && (elapsed < window_q);
	assign take      = accept && (in_beat.frame_code != 32'd0) && !is_repeat;

	assign house_byte = in_beat.frame_code[23:16];
	assign row_nib    = in_beat.frame_code[15:12];
	assign slider_nib = in_beat.frame_code[11:8];
	assign marker_nib = in_beat.frame_code[7:4];
	assign onoff_nib  = in_beat.frame_code[3:0];
	assign row_idx    = nib_idx(row_nib);
	assign slider_idx = nib_idx(slider_nib);
	assign on_flag    = (onoff_nib == ONOFF_ON);

	assign frame_ok = (in_beat.bit_count == FRAME_BITS) && house_hit(house_byte)
		&& nib_ok(row_nib) && nib_ok(slider_nib) && (marker_nib == MARKER_NIB)
		&& ((onoff_nib == ONOFF_ON) || (onoff_nib == ONOFF_OFF));

	assign q_push = take && frame_ok;

	always_comb begin
		q_data.house_index   = house_idx(house_byte);
		q_data.button_number = {1'b0, slider_idx, 3'b000} + {3'b000, row_idx, 1'b0}
			+ (on_flag ? 6'd1 : 6'd2);
		q_data.is_on         = on_flag;
		q_data.raw_code      = in_beat.frame_code;
		q_data.event_time_ms = in_beat.now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= DEBOUNCE_RESET_MS;
			last_code_q <= 32'd0;
			last_time_q <= 32'd0;
		end else begin
			if (cfg_we) window_q <= cfg_wdata;
			if (take) begin
				last_code_q <= in_beat.frame_code;
				last_time_q <= in_beat.now_ms;
			end
		end
	end

endmodule

### rtl/rffd_queue.sv
// ----------------------------------------------------------------------------
// rffd_queue: small fifo of decoded results between front and back
// circular buffer with read and write pointers and an occupancy count
// ----------------------------------------------------------------------------
module rffd_queue
	import rffd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_beat_t push_data,
	input  logic      pop,
	output logic      full,
	output logic      not_empty,
	output out_beat_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	out_beat_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

### rtl/rffd_back.sv
// ----------------------------------------------------------------------------
// rffd_back: output register driving the result channel
// pulls the queue head whenever the register is empty or being taken
// ----------------------------------------------------------------------------
module rffd_back
	import rffd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_not_empty,
	input  out_beat_t q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_beat
);

	logic      valid_q;
	out_beat_t data_q;

	assign q_pop     = q_not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_beat  = data_q;

	always_ff @(posedge clk) begin
		if (q_pop) data_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule
